@@ hdl/wbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard byte pattern matcher package
// Shared constants, register codes and word types of the matcher.
// ----------------------------------------------------------------------------
package wbpm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PAT_LEN_W    = 5;
  localparam int MASK_W       = 16;
  localparam int MATCH_OFFSET_W = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ONLY     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [MATCH_OFFSET_W-1:0] match_offset;
    logic                      is_match;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [PAT_LEN_W-1:0]  pattern_length;
    logic                  first_only;
  } cfg_t;

endpackage

@@ hdl/wbpm_cfg.sv @@
// ----------------------------------------------------------------------------
// Matcher configuration registers
// Holds pattern, wildcard mask, length and mode written over the cfg channel.
// ----------------------------------------------------------------------------
module wbpm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wbpm_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.wildcard_mask  <= '0;
      cfg.pattern_length <= wbpm_pkg::PAT_LEN_W'(1);
      cfg.first_only     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wbpm_pkg::REG_PATTERN_LOW: begin
          cfg.pattern_low <= cfg_data;
        end
        wbpm_pkg::REG_PATTERN_HIGH: begin
          cfg.pattern_high <= cfg_data;
        end
        wbpm_pkg::REG_WILDCARD_MASK: begin
          cfg.wildcard_mask <= cfg_data[wbpm_pkg::MASK_W-1:0];
        end
        wbpm_pkg::REG_PATTERN_LENGTH: begin
          cfg.pattern_length <= cfg_data[wbpm_pkg::PAT_LEN_W-1:0];
        end
        wbpm_pkg::REG_FIRST_ONLY: begin
          cfg.first_only <= cfg_data[0];
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

@@ hdl/wbpm_core.sv @@
// ----------------------------------------------------------------------------
// Matcher core
// Input register, byte window, offset counter and parallel byte compare.
// ----------------------------------------------------------------------------
module wbpm_core #(
  parameter int MAX_PATTERN_BYTES = wbpm_pkg::MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = wbpm_pkg::OFFSET_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  wbpm_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  wbpm_pkg::in_t   in_payload,
  output logic            res_valid,
  input  logic            res_ready,
  output wbpm_pkg::out_t  res_payload
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [wbpm_pkg::PAT_LEN_W-1:0] LEN_LIMIT =
    wbpm_pkg::PAT_LEN_W'(MAX_PATTERN_BYTES);

  logic                   s1_valid;
  wbpm_pkg::in_t          s1_word;
  logic                   s1_go;
  logic [7:0]             window [MAX_PATTERN_BYTES];
  logic [7:0]             window_next [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] count;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] offset;
  logic                   match_reported;
  logic [LEN_W-1:0]       len_used;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                   hit;
  logic                   emit;

  // clamp the programmed length into 1..MAX_PATTERN_BYTES
  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      len_used = LEN_W'(1);
    end else if (cfg.pattern_length > LEN_LIMIT) begin
      len_used = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_used = LEN_W'(cfg.pattern_length);
    end
  end

  // window as it stands once the current byte is shifted in
  assign window_next[0] = s1_word.data_byte;
  for (genvar k = 1; k < MAX_PATTERN_BYTES; k++) begin : g_shift
    assign window_next[k] = window[k-1];
  end

  // pattern byte i lines up with the byte len-1-i steps back
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cmp
    localparam logic [LEN_W-1:0] I_VAL = LEN_W'(i);
    logic [7:0]       pat_byte;
    logic [LEN_W-1:0] sel;

    if (i < 8) begin : g_lo
      assign pat_byte = cfg.pattern_low[8*i +: 8];
    end else begin : g_hi
      assign pat_byte = cfg.pattern_high[8*(i-8) +: 8];
    end

    assign sel = len_used - I_VAL - LEN_W'(1);
    assign byte_ok[i] = (I_VAL >= len_used) || cfg.wildcard_mask[i] ||
                        (window_next[sel[IDX_W-1:0]] == pat_byte);
  end

  // bytes of the region including the current one, saturating
  assign count   = (bytes_seen == '1) ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
  assign len_ext = OFFSET_BITS'(len_used);
  assign offset  = count - len_ext;

  assign hit  = (count >= len_ext) && (&byte_ok) &&
                !(cfg.first_only && match_reported);
  assign emit = hit || s1_word.last_byte;

  assign res_valid                = s1_valid && emit;
  assign res_payload.match_offset = hit ? wbpm_pkg::MATCH_OFFSET_W'(offset) : '0;
  assign res_payload.is_match     = hit;
  assign res_payload.last         = s1_word.last_byte;

  // advance unless a result is waiting on a full output stage
  assign s1_go    = s1_valid && (!emit || res_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        if (s1_word.last_byte) begin
          bytes_seen     <= '0;
          match_reported <= 1'b0;
        end else begin
          bytes_seen     <= count;
          match_reported <= match_reported || hit;
        end
      end
    end
  end

  // window bytes from an older region stay; hit ignores them until the count covers the pattern
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_payload;
    end
    if (s1_go) begin
      window <= window_next;
    end
  end

endmodule

@@ hdl/wbpm_out.sv @@
// ----------------------------------------------------------------------------
// Matcher result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module wbpm_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  output logic            res_ready,
  input  wbpm_pkg::out_t  res_payload,
  output logic            out_valid,
  input  logic            out_ready,
  output wbpm_pkg::out_t  out_payload
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_payload <= res_payload;
    end
  end

endmodule

@@ hdl/wildcard_byte_pattern_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Wildcard byte pattern matcher
// Scans a byte stream for a pattern of up to MAX_PATTERN_BYTES bytes, each
// pattern byte optionally a wildcard, and reports match start offsets.
//
// Usage:
//   cfg channel: index/data writes into pattern, mask, length and mode
//   registers; always ready. Write only while the scanner is idle.
//   in channel: one region byte per word, last_byte marks the region end.
//   out channel: a word per match (is_match=1) and one word on the final
//   byte of a region, flagged last (is_match=0 if no match ends there).
//   Path: a taken byte lands in the input register; its result, formed
//   combinationally from it, is held in the result register until out
//   takes it.
//   Throughput: one byte per cycle; the compare of all pattern bytes is
//   done in parallel in the single logic stage between the two registers.
//   When out stalls, bytes that produce no result keep flowing; a byte with
//   a result waits in the input register and in_ready drops behind it.
//   Reset clears the registers to pattern length one, all matches mode,
//   and starts a fresh region.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher_unit #(
  parameter int MAX_PATTERN_BYTES = wbpm_pkg::MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = wbpm_pkg::OFFSET_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wbpm_pkg::in_t                     in_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wbpm_pkg::out_t                    out_payload
);

  wbpm_pkg::cfg_t cfg;
  logic           res_valid;
  logic           res_ready;
  wbpm_pkg::out_t res_payload;

  wbpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wbpm_core #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_payload (res_payload)
  );

  wbpm_out u_out (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_payload (res_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

@@ verif/wbpm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern matcher scoreboard
// Watches the cfg, in and out channels of the matcher, tracks its registers,
// byte window and region counters, predicts the result word of every byte
// taken that yields one and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module wbpm_match_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [wbpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  wbpm_pkg::in_t                    in_payload,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  wbpm_pkg::out_t                   out_payload,
  output int                               mismatches,
  output int                               results_due
);

  // shadow registers
  logic [2*wbpm_pkg::CFG_DATA_W-1:0] pattern_q;
  logic [wbpm_pkg::MASK_W-1:0]       wild_q;
  logic [wbpm_pkg::PAT_LEN_W-1:0]    len_q;
  logic                              first_q;

  // shadow region state; window_q[k] is the byte k steps back
  logic [7:0]                       window_q [wbpm_pkg::MAX_PATTERN_BYTES];
  logic [wbpm_pkg::OFFSET_BITS-1:0] seen_q;
  logic                             reported_q;

  wbpm_pkg::out_t scan_results [$];
  int             miss_count = 0;

  function automatic void clear_region();
    int k;
    for (k = 0; k < wbpm_pkg::MAX_PATTERN_BYTES; k++) window_q[k] = '0;
    seen_q     = '0;
    reported_q = 1'b0;
  endfunction

  // Advance the window by one byte; return 1 when the byte yields a result word.
  function automatic bit scan_step(input wbpm_pkg::in_t word, output wbpm_pkg::out_t res);
    int unsigned                      n;
    int                               k;
    int                               i;
    logic [wbpm_pkg::OFFSET_BITS-1:0] count;
    bit                               hit;
    n = (len_q == 0) ? 1 :
        (len_q > wbpm_pkg::MAX_PATTERN_BYTES) ? wbpm_pkg::MAX_PATTERN_BYTES : len_q;
    for (k = wbpm_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = word.data_byte;
    // hold the counter once it saturates
    count  = (seen_q == '1) ? seen_q : seen_q + 1'b1;
    seen_q = count;
    hit = (count >= n);
    for (i = 0; i < n; i++) begin
      if (!wild_q[i] && window_q[n-1-i] != pattern_q[8*i +: 8]) hit = 1'b0;
    end
    if (first_q && reported_q) hit = 1'b0;
    res = '0;
    if (hit) begin
      reported_q       = 1'b1;
      res.match_offset = wbpm_pkg::MATCH_OFFSET_W'(count - n);
      res.is_match     = 1'b1;
    end
    res.last = word.last_byte;
    if (word.last_byte) clear_region();
    return hit || word.last_byte;
  endfunction

  always @(posedge clk) begin : monitor
    wbpm_pkg::out_t got;
    wbpm_pkg::out_t want;
    wbpm_pkg::out_t res;
    if (rst) begin
      pattern_q = '0;
      wild_q    = '0;
      len_q     = wbpm_pkg::PAT_LEN_W'(1);
      first_q   = 1'b0;
      clear_region();
      scan_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_payload;
        if (scan_results.size() == 0) begin
          $error("result word with none expected: match_offset %0d is_match %0b last %0b",
                 got.match_offset, got.is_match, got.last);
          miss_count++;
        end else begin
          want = scan_results.pop_front();
          if (got.match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, got %0d", want.match_offset, got.match_offset);
            miss_count++;
          end
          if (got.is_match !== want.is_match) begin
            $error("is_match: expected %0b, got %0b", want.is_match, got.is_match);
            miss_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            miss_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (scan_step(in_payload, res)) scan_results = {scan_results, res};
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wbpm_pkg::REG_PATTERN_LOW:
            pattern_q[wbpm_pkg::CFG_DATA_W-1:0] = cfg_data;
          wbpm_pkg::REG_PATTERN_HIGH:
            pattern_q[2*wbpm_pkg::CFG_DATA_W-1:wbpm_pkg::CFG_DATA_W] = cfg_data;
          wbpm_pkg::REG_WILDCARD_MASK:
            wild_q = cfg_data[wbpm_pkg::MASK_W-1:0];
          wbpm_pkg::REG_PATTERN_LENGTH:
            len_q = cfg_data[wbpm_pkg::PAT_LEN_W-1:0];
          wbpm_pkg::REG_FIRST_ONLY:
            first_q = cfg_data[0];
          default: ;
        endcase
      end
    end
    mismatches  <= miss_count;
    results_due <= scan_results.size();
  end

endmodule

@@ verif/tb_wildcard_byte_pattern_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern matcher testbench
// Programs pattern, wildcard mask, length and mode, streams byte regions with
// embedded, overlapping and corrupted pattern copies under random gaps and
// output stalls, and leaves result checking to the scoreboard module.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_matcher_unit;

  localparam int TOTAL_BYTES   = 525;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 80;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [wbpm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wbpm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  wbpm_pkg::in_t                    in_payload = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  wbpm_pkg::out_t                   out_payload;

  int mismatches;
  int results_due;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int hold_asked = 0;
  int hold_done = 0;
  bit gaps_on = 1'b1;
  bit receiver_steady = 1'b0;

  // current pattern as seen by the region builder
  logic [7:0]  pat_bytes [wbpm_pkg::MAX_PATTERN_BYTES];
  logic [15:0] cur_mask;
  int          eff_len;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wildcard_byte_pattern_matcher_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  wbpm_match_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_wildcard_byte_pattern_matcher_unit NOT OK");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_done != hold_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else if (receiver_steady || r < 65) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(15, 50)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fin);
    wbpm_pkg::in_t word;
    int            gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word.data_byte = b;
    word.last_byte = fin;
    in_valid   <= 1'b1;
    in_payload <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // drop valid, wait out every pending result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wbpm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wbpm_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all five registers; unused upper bits carry random noise
  task automatic load_pattern(input logic [127:0] pat, input logic [15:0] mask,
                              input logic [4:0] len, input logic first);
    logic [wbpm_pkg::CFG_DATA_W-1:0] v;
    int                              i;
    for (i = 0; i < wbpm_pkg::MAX_PATTERN_BYTES; i++) pat_bytes[i] = pat[8*i +: 8];
    cur_mask = mask;
    eff_len  = (len == 0) ? 1 :
               (len > wbpm_pkg::MAX_PATTERN_BYTES) ? wbpm_pkg::MAX_PATTERN_BYTES : len;
    write_reg(wbpm_pkg::REG_PATTERN_LOW, pat[63:0]);
    write_reg(wbpm_pkg::REG_PATTERN_HIGH, pat[127:64]);
    v = {$urandom, $urandom};
    v[wbpm_pkg::MASK_W-1:0] = mask;
    write_reg(wbpm_pkg::REG_WILDCARD_MASK, v);
    v = {$urandom, $urandom};
    v[wbpm_pkg::PAT_LEN_W-1:0] = len;
    write_reg(wbpm_pkg::REG_PATTERN_LENGTH, v);
    v = {$urandom, $urandom};
    v[0] = first;
    write_reg(wbpm_pkg::REG_FIRST_ONLY, v);
    cfg_valid <= 1'b0;
  endtask

  // one region: pattern copies (some corrupted or cut short), pattern bytes, noise
  task automatic scan_region();
    logic [7:0] region [$];
    logic [7:0] b;
    int         nbytes;
    int         r;
    int         j;
    int         pick;
    r = $urandom_range(0, 99);
    if (r < 12) nbytes = $urandom_range(1, eff_len);
    else if (r < 92) nbytes = eff_len + $urandom_range(0, 20);
    else nbytes = eff_len + $urandom_range(21, 60);
    while (region.size() < nbytes) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pick = (r < 15) ? $urandom_range(0, eff_len - 1) : -1;
        for (j = 0; j < eff_len; j++) begin
          b = 8'($urandom);
          if (!cur_mask[j]) b = pat_bytes[j];
          if (j == pick) b = ~b;
          region = {region, b};
        end
      end else if (r < 80) begin
        region = {region, pat_bytes[$urandom_range(0, eff_len - 1)]};
      end else begin
        b = 8'($urandom);
        region = {region, b};
      end
    end
    for (j = 0; j < nbytes; j++) push_byte(region[j], j == nbytes - 1);
  endtask

  task automatic random_phase();
    logic [127:0] pat;
    logic [15:0]  mask;
    logic [4:0]   len;
    int           r;
    pat = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    // repeated bytes give overlapping matches
    if (r < 20) pat = {16{pat[7:0]}};
    else if (r < 35) pat = {8{pat[15:0]}};
    r = $urandom_range(0, 99);
    if (r < 40) mask = '0;
    else if (r < 65) mask = 16'($urandom & $urandom);
    else if (r < 90) mask = 16'($urandom);
    else mask = '1;
    r = $urandom_range(0, 99);
    if (r < 15) len = 5'd1;
    else if (r < 30) len = 5'd16;
    else if (r < 38) len = 5'd0;
    else if (r < 48) len = 5'($urandom_range(17, 31));
    else len = 5'($urandom_range(2, 15));
    load_pattern(pat, mask, len, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 4)) scan_region();
    settle();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: single zero byte pattern, all matches
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // wildcard in the middle, second match ends on the final byte
    load_pattern({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_EF00_ADDE}, 16'hFFF4, 5'd4, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEF, 1'b1);
    settle();

    // length above range acts as sixteen; region shorter than the pattern
    load_pattern('0, 16'hFFFF, 5'd31, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // length zero acts as one; first-only suppresses the repeat
    load_pattern({64'h0, 64'hFF}, 16'h0000, 5'd0, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle();
    // switch to all matches mid-region
    load_pattern({64'h0, 64'hFF}, 16'h0000, 5'd0, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // every byte matches while the result side holds off
    load_pattern({$urandom, $urandom, $urandom, $urandom}, 16'h0001, 5'd1, 1'b0);
    gaps_on = 1'b0;
    hold_asked++;
    repeat (39) push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b1);
    gaps_on = 1'b1;
    settle();

    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 99) < 15) begin
        gaps_on         = 1'b0;
        receiver_steady = 1'b1;
        random_phase();
        gaps_on         = 1'b1;
        receiver_steady = 1'b0;
      end else begin
        random_phase();
      end
    end

    if (results_due != 0) $error("%0d expected result words never arrived", results_due);
    if (mismatches == 0 && results_due == 0) begin
      $display("tb_wildcard_byte_pattern_matcher_unit OK");
    end else begin
      $display("tb_wildcard_byte_pattern_matcher_unit NOT OK");
    end
    $finish;
  end

endmodule
